>>> sv/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg: shared types and byte classes of the pre-tokenize segmenter
// Chunk kinds, the chunk tracking state and the result word layout.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 3;
  localparam int WIN_DEPTH = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_CONTRACTION = 3'd0,
    KIND_LETTERS     = 3'd1,
    KIND_DIGITS      = 3'd2,
    KIND_SP_LETTERS  = 3'd3,
    KIND_SP_DIGITS   = 3'd4,
    KIND_WHITESPACE  = 3'd5,
    KIND_OTHER       = 3'd6
  } chunk_kind_t;

  typedef struct packed {
    chunk_kind_t kind;
    logic        in_chunk;
    logic [1:0]  forced_left;
    logic [1:0]  skip_left;
  } chunk_state_t;

  typedef struct packed {
    logic              done;
    chunk_kind_t       kind;
    logic              start;
    logic [BYTE_W-1:0] data;
  } out_word_t;

  function automatic logic is_letter(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] l;
    l = b | 8'h20;
    return !b[7] && (l inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic is_wordish(input logic [BYTE_W-1:0] b);
    return is_letter(b) || b[7];
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return b inside {8'h20, 8'h0A, 8'h0D, 8'h09};
  endfunction

  function automatic logic [BYTE_W-1:0] lower_of(input logic [BYTE_W-1:0] b);
    return is_letter(b) ? (b | 8'h20) : b;
  endfunction

  function automatic logic [1:0] lead_skip(input logic [BYTE_W-1:0] b);
    logic [1:0] s;
    if ((b & 8'hE0) == 8'hC0) begin
      s = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      s = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0) begin
      s = 2'd3;
    end else begin
      s = 2'd0;
    end
    return s;
  endfunction

endpackage

>>> sv/text_pretokenize_segmenter.sv
// ----------------------------------------------------------------------------
// text_pretokenize_segmenter: byte stream pre-tokenizer
// Marks chunk starts and chunk kinds of a text using two bytes of lookahead.
// ----------------------------------------------------------------------------
//   channel  direction  payload
//   in_      slave      tdata text byte, tlast end of text
//   out_     master     tdata byte, tuser start and kind, tlast text done
//
// One byte is taken per cycle unless the text is draining or the window is full
// and the output stalled; a byte's word is loaded into the output register once
// two later bytes have arrived and the output is free. End of text drains the
// held bytes one per cycle while the output is free, and input waits while the
// window empties. Reset empties the window and the output register and clears
// the chunk state. A stalled output holds words in the window until it is full.
module text_pretokenize_segmenter
  import tps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [3:0] out_tuser,  // [0] chunk_start, [3:1] chunk_kind
  output logic       out_tlast
);

  logic [BYTE_W-1:0] win_r [WIN_DEPTH];
  logic [BYTE_W-1:0] win_nxt [WIN_DEPTH];
  logic [1:0]        cnt_r;
  logic [1:0]        cnt_nxt;
  logic [1:0]        cnt_shift;
  logic              flush_r;
  logic              flush_nxt;
  chunk_state_t      st_r;
  chunk_state_t      st_nxt;
  chunk_state_t      dec_st;
  logic              dec_start;
  logic              out_free;
  logic              fire;
  logic              last_fire;
  logic              in_fire;
  logic [1:0]        ahead;
  logic [BYTE_W-1:0] b1;
  logic [BYTE_W-1:0] b2;
  out_word_t         word;

  assign fire      = out_free && (cnt_r == 2'd3 || (flush_r && cnt_r != 2'd0));
  assign last_fire = fire && flush_r && cnt_r == 2'd1;
  assign in_tready = !flush_r && (cnt_r != 2'd3 || out_free);
  assign in_fire   = in_tvalid && in_tready;

  assign ahead = cnt_r - 2'd1;
  assign b1    = (ahead >= 2'd1) ? win_r[1] : '0;
  assign b2    = (ahead >= 2'd2) ? win_r[2] : '0;

  tps_decide u_decide (
    .b0     (win_r[0]),
    .b1     (b1),
    .b2     (b2),
    .ahead  (ahead),
    .st     (st_r),
    .start  (dec_start),
    .st_nxt (dec_st)
  );

  always_comb begin
    word.data  = win_r[0];
    word.start = dec_start;
    word.kind  = dec_st.kind;
    word.done  = flush_r && cnt_r == 2'd1;
  end

  always_comb begin
    win_nxt   = win_r;
    cnt_shift = cnt_r;
    if (fire) begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      cnt_shift  = cnt_r - 2'd1;
    end
    cnt_nxt = cnt_shift;
    if (in_fire) begin
      win_nxt[cnt_shift] = in_tdata;
      cnt_nxt            = cnt_shift + 2'd1;
    end
  end

  always_comb begin
    flush_nxt = flush_r;
    if (in_fire && in_tlast) begin
      flush_nxt = 1'b1;
    end else if (last_fire) begin
      flush_nxt = 1'b0;
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (last_fire) begin
      st_nxt = '0;
    end else if (fire) begin
      st_nxt = dec_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 2'd0;
      flush_r <= 1'b0;
      st_r    <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
      st_r    <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  tps_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .word       (word),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sv/tps_decide.sv
// ----------------------------------------------------------------------------
// tps_decide: chunk decision for the oldest byte of the window
// Labels one byte from itself, up to two lookahead bytes and the chunk state.
// ----------------------------------------------------------------------------
module tps_decide
  import tps_pkg::*;
(
  input  logic [BYTE_W-1:0] b0,
  input  logic [BYTE_W-1:0] b1,
  input  logic [BYTE_W-1:0] b2,
  input  logic [1:0]        ahead,
  input  chunk_state_t      st,
  output logic              start,
  output chunk_state_t      st_nxt
);

  logic              cont;
  logic [BYTE_W-1:0] l1;
  logic [BYTE_W-1:0] l2;

  assign l1 = lower_of(b1);
  assign l2 = lower_of(b2);

  always_comb begin
    cont = 1'b0;
    if (st.in_chunk) begin
      case (st.kind)
        KIND_LETTERS, KIND_SP_LETTERS: cont = is_wordish(b0);
        KIND_DIGITS, KIND_SP_DIGITS:   cont = is_digit(b0);
        KIND_WHITESPACE:               cont = is_space(b0);
        default:                       cont = 1'b0;
      endcase
    end
  end

  always_comb begin
    st_nxt = st;
    start  = 1'b0;
    if (st.skip_left != 2'd0) begin
      st_nxt.skip_left = st.skip_left - 2'd1;
    end else if (st.forced_left != 2'd0) begin
      st_nxt.forced_left = st.forced_left - 2'd1;
    end else if (cont) begin
      if (b0[7]) begin
        st_nxt.skip_left = lead_skip(b0);
      end
    end else begin
      start = 1'b1;
      st_nxt.in_chunk = 1'b1;
      if (b0 == 8'h27 && ahead >= 2'd1 && (l1 inside {8'h73, 8'h74, 8'h6D, 8'h64})) begin
        st_nxt.kind        = KIND_CONTRACTION;
        st_nxt.forced_left = 2'd1;
      end else if (b0 == 8'h27 && ahead >= 2'd2 &&
                   ((l1 == 8'h72 && l2 == 8'h65) || (l1 == 8'h76 && l2 == 8'h65) ||
                    (l1 == 8'h6C && l2 == 8'h6C))) begin
        st_nxt.kind        = KIND_CONTRACTION;
        st_nxt.forced_left = 2'd2;
      end else if (is_wordish(b0)) begin
        st_nxt.kind = KIND_LETTERS;
        if (b0[7]) begin
          st_nxt.skip_left = lead_skip(b0);
        end
      end else if (is_digit(b0)) begin
        st_nxt.kind = KIND_DIGITS;
      end else if (b0 == 8'h20 && ahead >= 2'd1 && is_wordish(b1)) begin
        st_nxt.kind = KIND_SP_LETTERS;
      end else if (b0 == 8'h20 && ahead >= 2'd1 && is_digit(b1)) begin
        st_nxt.kind = KIND_SP_DIGITS;
      end else if (is_space(b0)) begin
        st_nxt.kind = KIND_WHITESPACE;
      end else begin
        st_nxt.kind = KIND_OTHER;
      end
    end
  end

endmodule

>>> sv/tps_out_stage.sv
// ----------------------------------------------------------------------------
// tps_out_stage: result register of the segmenter
// Holds one labelled word until the downstream side takes it.
// ----------------------------------------------------------------------------
module tps_out_stage
  import tps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  out_word_t   word,
  output logic        free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic [3:0]  out_tuser,
  output logic        out_tlast
);

  logic      valid_r;
  logic      valid_nxt;
  out_word_t word_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = word_r.data;
  assign out_tuser  = {word_r.kind, word_r.start};
  assign out_tlast  = word_r.done;

endmodule
